// ===== hw/rtl/cht_pkg.sv =====
// Shared types and constants for the chained hash table.
package cht_pkg;

    // Fixed field widths of the item and result words.
    localparam int KEY_W    = 31;
    localparam int PROBE_W  = 5;
    localparam int PROBE_MAX = 31;

    // Opcode values of an input word.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Saturate a probe count to the width of the result field.
    function automatic logic [PROBE_W-1:0] sat_probe(input logic [7:0] v);
        logic [PROBE_W-1:0] res;
        if (v > 8'(PROBE_MAX)) begin
            res = PROBE_W'(PROBE_MAX);
        end else begin
            res = v[PROBE_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/cht_mod.sv =====
// Bucket remainder unit: key modulo the bucket count from byte residue tables.
module cht_mod
    import cht_pkg::*;
#(
    parameter int NUM_BUCKETS = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [KEY_W-1:0]               i_key,
    output logic                           o_done,
    output logic [$clog2(NUM_BUCKETS)-1:0] o_rem
);
    localparam int BW = $clog2(NUM_BUCKETS);
    localparam int TW = 256 * BW;
    localparam logic [BW+1:0] M1 = (BW+2)'(NUM_BUCKETS);
    localparam logic [BW+1:0] M2 = (BW+2)'(2 * NUM_BUCKETS);
    localparam logic [BW+1:0] M3 = (BW+2)'(3 * NUM_BUCKETS);

    // Residue of every byte value at one byte position of the key, built at elaboration.
    function automatic logic [TW-1:0] byte_table(input int pos);
        logic [TW-1:0] t;
        int            w;
        w = 1;
        for (int i = 0; i < pos; i++) begin
            w = (w * 256) % NUM_BUCKETS;
        end
        t = '0;
        for (int v = 0; v < 256; v++) begin
            t[v*BW +: BW] = BW'((v * w) % NUM_BUCKETS);
        end
        return t;
    endfunction

    localparam logic [TW-1:0] T0 = byte_table(0);
    localparam logic [TW-1:0] T1 = byte_table(1);
    localparam logic [TW-1:0] T2 = byte_table(2);
    localparam logic [TW-1:0] T3 = byte_table(3);

    logic [31:0]     w_key_pad;
    logic [BW-1:0]   w_res0;
    logic [BW-1:0]   w_res1;
    logic [BW-1:0]   w_res2;
    logic [BW-1:0]   w_res3;
    logic [BW+1:0]   w_sum;
    logic [BW+1:0]   r_sum;
    logic [BW-1:0]   r_rem;
    logic            r_busy;
    logic            r_done;
    logic [BW+1:0]   w_next;

    // First step: each key byte maps to its residue, and the four residues are summed.
    assign w_key_pad = {1'b0, i_key};
    assign w_res0    = T0[int'(w_key_pad[7:0]) * BW +: BW];
    assign w_res1    = T1[int'(w_key_pad[15:8]) * BW +: BW];
    assign w_res2    = T2[int'(w_key_pad[23:16]) * BW +: BW];
    assign w_res3    = T3[int'(w_key_pad[31:24]) * BW +: BW];
    assign w_sum     = (BW+2)'(w_res0) + (BW+2)'(w_res1) + (BW+2)'(w_res2)
                     + (BW+2)'(w_res3);

    // Second step: the sum stays below four times the divisor, so one compare
    // and subtract step leaves the remainder.
    always_comb begin
        if (r_sum >= M3) begin
            w_next = r_sum - M3;
        end else if (r_sum >= M2) begin
            w_next = r_sum - M2;
        end else if (r_sum >= M1) begin
            w_next = r_sum - M1;
        end else begin
            w_next = r_sum;
        end
    end

    // Control of the two steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    // Datapath of the residue sum and the remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum <= w_sum;
        end
        if (r_busy) begin
            r_rem <= w_next[BW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hw/rtl/cht_key_mem.sv =====
// Key store: one write port and one registered read port.
module cht_key_mem
    import cht_pkg::*;
#(
    parameter int DEPTH = 160
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [KEY_W-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [KEY_W-1:0]         o_rdata
);
    logic [KEY_W-1:0] r_mem [0:DEPTH-1];
    logic [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/cht_len_mem.sv =====
// Chain length store with per-bucket valid bits, so reset empties every chain.
module cht_len_mem
    import cht_pkg::*;
#(
    parameter int NUM_BUCKETS = 10,
    parameter int CHAIN_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_we,
    input  logic [$clog2(NUM_BUCKETS)-1:0]     i_waddr,
    input  logic [$clog2(CHAIN_DEPTH+1)-1:0]   i_wdata,
    input  logic [$clog2(NUM_BUCKETS)-1:0]     i_raddr,
    output logic [$clog2(CHAIN_DEPTH+1)-1:0]   o_rdata
);
    localparam int LW = $clog2(CHAIN_DEPTH + 1);

    logic [LW-1:0]          r_mem [0:NUM_BUCKETS-1];
    logic [NUM_BUCKETS-1:0] r_valid;
    logic [LW-1:0]          r_rdata;
    logic                   r_rvalid;

    // Valid bits: cleared at reset, set by the first write to a bucket.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    // Storage array and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // A bucket never written reads as an empty chain.
    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

// ===== hw/rtl/chained_hash_table.sv =====
// Hash table with separate chaining: sequencer around the key and length stores.
//
// Input channel: i_in_valid, o_in_stall, i_opcode (insert or search), i_key.
// Output channel: o_out_valid, i_out_stall, o_status, o_probe_count.
// A word moves at a rising edge where valid is high and stall is low.
// Each input word yields exactly one result word, in order.
// The bucket is the key modulo NUM_BUCKETS, found by a remainder unit from
// byte residue tables. The chain length is then read, and a search reads the
// chain one stored key per cycle from its head, comparing at most CHAIN_DEPTH
// keys; an insert or a search of an empty chain does not scan. The input
// stalls from accept until the result is loaded into the output register, so
// a new word is taken no earlier than the cycle after that, and never before
// the last word is through.
// A stalled output holds its word; a finished result waits until the output
// register frees up, and the input stays stalled meanwhile.
// Synchronous reset empties every chain at once.
module chained_hash_table
    import cht_pkg::*;
#(
    parameter int NUM_BUCKETS = 10,
    parameter int CHAIN_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_opcode,
    input  logic [KEY_W-1:0]   i_key,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [PROBE_W-1:0] o_probe_count
);
    localparam int BW    = $clog2(NUM_BUCKETS);
    localparam int LW    = $clog2(CHAIN_DEPTH + 1);
    localparam int DEPTH = NUM_BUCKETS * CHAIN_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HASH = 5'b00010,
        S_LEN  = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic               r_op;
    logic [KEY_W-1:0]   r_key;
    logic [BW-1:0]      r_bucket;
    logic [AW-1:0]      r_base;
    logic [LW-1:0]      r_len, n_len;
    logic [LW-1:0]      r_cmp_idx, n_cmp_idx;
    t_status            r_res_status, n_res_status;
    logic [PROBE_W-1:0] r_res_probe, n_res_probe;
    logic               r_out_valid;
    t_status            r_out_status;
    logic [PROBE_W-1:0] r_out_probe;

    logic               w_in_accept;
    logic               w_load_out;
    logic               w_mod_done;
    logic [BW-1:0]      w_mod_rem;
    logic [LW-1:0]      w_len_rdata;
    logic               w_len_we;
    logic [LW-1:0]      w_len_wdata;
    logic               w_key_we;
    logic [AW-1:0]      w_key_waddr;
    logic [AW-1:0]      w_key_raddr;
    logic [KEY_W-1:0]   w_key_rdata;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);

    cht_mod #(
        .NUM_BUCKETS(NUM_BUCKETS)
    ) u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_in_accept),
        .i_key  (i_key),
        .o_done (w_mod_done),
        .o_rem  (w_mod_rem)
    );

    cht_len_mem #(
        .NUM_BUCKETS(NUM_BUCKETS),
        .CHAIN_DEPTH(CHAIN_DEPTH)
    ) u_len_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (w_len_we),
        .i_waddr(r_bucket),
        .i_wdata(w_len_wdata),
        .i_raddr(w_mod_rem),
        .o_rdata(w_len_rdata)
    );

    cht_key_mem #(
        .DEPTH(DEPTH)
    ) u_key_mem (
        .i_clk  (i_clk),
        .i_we   (w_key_we),
        .i_waddr(w_key_waddr),
        .i_wdata(r_key),
        .i_raddr(w_key_raddr),
        .o_rdata(w_key_rdata)
    );

    // Store addresses: the insert slot is at the chain tail, the scan
    // reads the entry after the one being compared.
    assign w_key_waddr = r_base + AW'(w_len_rdata);
    assign w_len_wdata = w_len_rdata + LW'(1);
    always_comb begin
        if (r_state == S_SCAN) begin
            w_key_raddr = r_base + AW'(r_cmp_idx) + AW'(1);
        end else begin
            w_key_raddr = r_base;
        end
    end

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_cmp_idx    = r_cmp_idx;
        n_res_status = r_res_status;
        n_res_probe  = r_res_probe;
        w_len_we     = 1'b0;
        w_key_we     = 1'b0;
        w_load_out   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (w_mod_done) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                n_len     = w_len_rdata;
                n_cmp_idx = '0;
                if (r_op == OP_INSERT) begin
                    n_res_probe = '0;
                    n_state     = S_DONE;
                    if (w_len_rdata == LW'(CHAIN_DEPTH)) begin
                        n_res_status = ST_FULL;
                    end else begin
                        n_res_status = ST_INSERTED;
                        w_len_we     = 1'b1;
                        w_key_we     = 1'b1;
                    end
                end else if (w_len_rdata == '0) begin
                    n_res_status = ST_NOT_FOUND;
                    n_res_probe  = sat_probe(8'd1);
                    n_state      = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_key_rdata == r_key) begin
                    n_res_status = ST_FOUND;
                    n_res_probe  = sat_probe(8'(r_cmp_idx));
                    n_state      = S_DONE;
                end else if (r_cmp_idx + LW'(1) == r_len) begin
                    n_res_status = ST_NOT_FOUND;
                    n_res_probe  = sat_probe(8'(r_len) + 8'd1);
                    n_state      = S_DONE;
                end else begin
                    n_cmp_idx = r_cmp_idx + LW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_op  <= i_opcode;
            r_key <= i_key;
        end
        if (r_state == S_HASH && w_mod_done) begin
            r_bucket <= w_mod_rem;
            r_base   <= AW'(w_mod_rem) * AW'(CHAIN_DEPTH);
        end
        r_len        <= n_len;
        r_cmp_idx    <= n_cmp_idx;
        r_res_status <= n_res_status;
        r_res_probe  <= n_res_probe;
        if (w_load_out) begin
            r_out_status <= r_res_status;
            r_out_probe  <= r_res_probe;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_probe_count = r_out_probe;

    // The remainder unit only finishes while the sequencer waits for it.
    a_mod_done_in_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> r_state == S_HASH)
        else $error("bucket remainder finished outside the hash step");

    // A scan never compares past the chain length.
    a_scan_in_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_cmp_idx < r_len)
        else $error("chain scan ran past the chain length");

    // A chain never grows beyond its depth.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_len_we |-> w_len_wdata <= LW'(CHAIN_DEPTH))
        else $error("chain length written beyond the chain depth");

    // Insert results carry a zero probe count; a miss counts at least one.
    a_probe_by_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> ((r_out_status == ST_INSERTED || r_out_status == ST_FULL)
            ? r_out_probe == '0
            : (r_out_status == ST_NOT_FOUND ? r_out_probe != '0 : 1'b1)))
        else $error("probe count does not match the result status");

endmodule
